// ===== hdl/u8d_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_pkg
// shared types and constants for the utf-8 stream decoder
// ----------------------------------------------------------------------------
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int U8D_QUEUE_DEPTH = 4;

    localparam logic [7:0]  LEAD2_LO     = 8'hC2;
    localparam logic [7:0]  LEAD2_HI     = 8'hDF;
    localparam logic [7:0]  LEAD3_LO     = 8'hE0;
    localparam logic [7:0]  LEAD3_HI     = 8'hEF;
    localparam logic [7:0]  LEAD4_LO     = 8'hF0;
    localparam logic [7:0]  LEAD4_HI     = 8'hF4;
    localparam logic [20:0] MIN_CODE3    = 21'h000800;
    localparam logic [20:0] SURR_LO      = 21'h00D800;
    localparam logic [20:0] SURR_HI      = 21'h00DFFF;
    localparam logic [20:0] MIN_CODE4    = 21'h010000;
    localparam logic [20:0] MAX_CODE     = 21'h10FFFF;
    localparam logic [20:0] REPLACEMENT  = 21'h00003F;

    localparam logic [2:0]  LEN_NONE     = 3'd0;
    localparam logic [2:0]  LEN_TWO      = 3'd2;
    localparam logic [2:0]  LEN_THREE    = 3'd3;
    localparam logic [2:0]  LEN_FOUR     = 3'd4;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_end;
    } u8d_in_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        replaced;
        logic        run_last;
    } u8d_out_t;

    // one accepted byte's worth of results: rep_count replacements,
    // then the decoded code if code_en
    typedef struct packed {
        logic [2:0]  rep_count;
        logic        code_en;
        logic [20:0] code;
    } u8d_desc_t;

endpackage
`default_nettype wire

// ===== hdl/u8d_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_front
// accepts bytes, tracks the open sequence and classifies each byte
// into a result descriptor
// ----------------------------------------------------------------------------
module u8d_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  u8d_pkg::u8d_in_t  s_data,
    input  wire               q_full,
    output logic              push,
    output u8d_pkg::u8d_desc_t push_data
);
    import u8d_pkg::*;

    logic [20:0] pc_reg, pc_next;
    logic [2:0]  el_reg, el_next;
    logic [1:0]  hc_reg, hc_next;

    logic        accept;
    logic        seq_open;
    logic        is_cont;
    logic        take_lead;
    logic [20:0] cont_code;
    logic [1:0]  cont_hc;
    logic        code_ok;
    logic [7:0]  b;
    logic [2:0]  rep;
    logic        code_en;
    logic [20:0] code;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.text_byte;

    always_comb begin
        seq_open  = (el_reg inside {LEN_TWO, LEN_THREE, LEN_FOUR}) && (hc_reg != 2'd0);
        is_cont   = (b[7:6] == 2'b10);
        cont_code = {pc_reg[14:0], b[5:0]};
        cont_hc   = hc_reg + 2'd1;
        case (el_reg)
            LEN_THREE: begin
                code_ok = (cont_code >= MIN_CODE3) &&
                          ((cont_code < SURR_LO) || (cont_code > SURR_HI));
            end
            LEN_FOUR: begin
                code_ok = (cont_code >= MIN_CODE4) && (cont_code <= MAX_CODE);
            end
            default: begin
                code_ok = 1'b1;
            end
        endcase

        rep       = 3'd0;
        code_en   = 1'b0;
        code      = '0;
        pc_next   = pc_reg;
        el_next   = el_reg;
        hc_next   = hc_reg;
        take_lead = 1'b0;

        if (!seq_open) begin
            pc_next   = '0;
            el_next   = LEN_NONE;
            hc_next   = 2'd0;
            take_lead = 1'b1;
        end else if (is_cont) begin
            pc_next = cont_code;
            hc_next = cont_hc;
            if ((cont_hc == 2'd0) || ({1'b0, cont_hc} >= el_reg)) begin
                if (code_ok) begin
                    code_en = 1'b1;
                    code    = cont_code;
                end else begin
                    rep = el_reg;
                end
                pc_next = '0;
                el_next = LEN_NONE;
                hc_next = 2'd0;
            end
        end else begin
            rep       = {1'b0, hc_reg};
            pc_next   = '0;
            el_next   = LEN_NONE;
            hc_next   = 2'd0;
            take_lead = 1'b1;
        end

        if (take_lead) begin
            if (b == 8'h00) begin
                // terminator emits nothing itself
            end else if (b[7] == 1'b0) begin
                code_en = 1'b1;
                code    = {13'd0, b};
            end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
                pc_next = {16'd0, b[4:0]};
                el_next = LEN_TWO;
                hc_next = 2'd1;
            end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
                pc_next = {17'd0, b[3:0]};
                el_next = LEN_THREE;
                hc_next = 2'd1;
            end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
                pc_next = {18'd0, b[2:0]};
                el_next = LEN_FOUR;
                hc_next = 2'd1;
            end else begin
                rep = rep + 3'd1;
            end
        end

        if (s_data.text_end) begin
            rep     = rep + {1'b0, hc_next};
            pc_next = '0;
            el_next = LEN_NONE;
            hc_next = 2'd0;
        end

        push                = accept && ((rep != 3'd0) || code_en);
        push_data.rep_count = rep;
        push_data.code_en   = code_en;
        push_data.code      = code;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= '0;
            el_reg <= LEN_NONE;
            hc_reg <= 2'd0;
        end else if (accept) begin
            pc_reg <= pc_next;
            el_reg <= el_next;
            hc_reg <= hc_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/u8d_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_queue
// small first-in first-out buffer of result descriptors
// ----------------------------------------------------------------------------
module u8d_queue #(
    parameter int DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                push,
    input  u8d_pkg::u8d_desc_t push_data,
    input  wire                pop,
    output logic               full,
    output logic               head_valid,
    output u8d_pkg::u8d_desc_t head
);
    import u8d_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    u8d_desc_t     mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (cnt_reg == FULL_CNT);
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/u8d_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8d_back
// expands descriptors into result transactions, one per cycle while not stalled,
// through a registered output stage
// ----------------------------------------------------------------------------
module u8d_back (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                head_valid,
    input  u8d_pkg::u8d_desc_t head,
    output logic               pop,
    output logic               m_valid,
    input  wire                m_ready,
    output u8d_pkg::u8d_out_t  m_data
);
    import u8d_pkg::*;

    logic      cur_valid_reg, cur_valid_next;
    u8d_desc_t cur_reg, cur_next;
    logic      m_valid_reg, m_valid_next;
    u8d_out_t  m_data_reg, m_data_next;

    logic      adv;
    logic      last;
    u8d_out_t  res;

    always_comb begin
        last = (cur_reg.rep_count == 3'd1 && !cur_reg.code_en) ||
               (cur_reg.rep_count == 3'd0);
        if (cur_reg.rep_count != 3'd0) begin
            res.code_point = REPLACEMENT;
            res.replaced   = 1'b1;
        end else begin
            res.code_point = cur_reg.code;
            res.replaced   = 1'b0;
        end
        res.run_last = last;

        adv = cur_valid_reg && (!m_valid_reg || m_ready);
        pop = head_valid && (!cur_valid_reg || (adv && last));

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (adv) begin
            m_valid_next = 1'b1;
            m_data_next  = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            cur_next       = head;
        end else if (adv) begin
            if (last) begin
                cur_valid_next = 1'b0;
            end else begin
                cur_next.rep_count = cur_reg.rep_count - 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ===== hdl/utf8_stream_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// streaming utf-8 decoder: one text byte in, zero to four code points out
// ----------------------------------------------------------------------------
//  channel  ports                    payload
//  input    s_valid/s_ready/s_data   text_byte, text_end
//  result   m_valid/m_ready/m_data   code_point, replaced, run_last
//
//  one byte is taken per cycle while the descriptor queue has room
//  the back end emits one result per cycle while m_ready allows; a byte with
//  several results holds it until all are sent, so such bytes or a stalled
//  result channel can fill the queue and slow the input
//  reset clears the open sequence, the queue and the output stage
// ----------------------------------------------------------------------------
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = u8d_pkg::U8D_QUEUE_DEPTH
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  u8d_pkg::u8d_in_t  s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output u8d_pkg::u8d_out_t m_data
);
    import u8d_pkg::*;

    logic      q_full;
    logic      push;
    u8d_desc_t push_data;
    logic      pop;
    logic      head_valid;
    u8d_desc_t head;

    u8d_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head       (head)
    );

    u8d_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
`default_nettype wire
